// File: rtl/jacm_pkg.sv
// ----------------------------------------------------------------------------
// jacm_pkg
// Shared widths, register indexes, reset values and helpers for the
// calibrated joystick axis mapper.
// ----------------------------------------------------------------------------
package jacm_pkg;

  // Channel payload widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned MARGIN_W   = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam int unsigned INDEX_SPAN_DEF = 512;

  // Signed working width for index arithmetic (covers -1533..1533)
  localparam int unsigned CAL_W  = 12;
  // Map product magnitude (up to 1022 * 127), divisor magnitude, product width
  localparam int unsigned NUM_W  = 17;
  localparam int unsigned DEN_W  = 11;
  localparam int unsigned PROD_W = 20;
  // Map gain of 127 is built as (x << 7) - x
  localparam int unsigned GAIN_SHIFT = 7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EARLY_STOP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_AXIS = 3'd5;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] AXIS_MIN_RST   = 10'd330;
  localparam logic [SAMPLE_W-1:0] AXIS_MID_RST   = 10'd512;
  localparam logic [SAMPLE_W-1:0] AXIS_MAX_RST   = 10'd830;
  localparam logic [MARGIN_W-1:0] EARLY_STOP_RST = 9'd30;
  localparam logic [MARGIN_W-1:0] DEAD_BAND_RST  = 9'd10;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 10'd1023;
  localparam logic [VALUE_W-1:0]  VALUE_LOW    = 8'd0;
  localparam logic [VALUE_W-1:0]  VALUE_CENTRE = 8'd127;
  localparam logic [VALUE_W-1:0]  VALUE_FULL   = 8'd254;

  typedef enum logic [1:0] {
    OVR_NONE,
    OVR_ZERO,
    OVR_CENTRE,
    OVR_FULL
  } ovr_e;

  // (a - b) / 2, truncating toward zero
  function automatic logic signed [CAL_W-1:0] half_diff(
    input logic [SAMPLE_W-1:0] a,
    input logic [SAMPLE_W-1:0] b
  );
    logic signed [CAL_W-1:0] d;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    return (d + $signed({{(CAL_W-1){1'b0}}, d[CAL_W-1]})) >>> 1;
  endfunction

endpackage

// File: rtl/jacm_if.sv
// ----------------------------------------------------------------------------
// jacm channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface jacm_sample_if
  import jacm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface jacm_result_if
  import jacm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] axis_value;
  logic               index_clamped;

  modport source (output valid, output axis_value, output index_clamped, input ready);
  modport sink   (input valid, input axis_value, input index_clamped, output ready);
endinterface

interface jacm_cfg_if
  import jacm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/joystick_axis_calibrated_map.sv
// Each accepted sample beat passes stages A, B and C, the divider stages and the
// final stage to its result beat on the output register; one sample per cycle sustained while result_o.ready holds.
// The 17-stage restoring divider (one quotient bit per stage) sets the depth.
// Stages advance independently, so bubbles close up while the output stalls.
// Reset empties the pipeline and loads the default calibration registers.
// ----------------------------------------------------------------------------
// joystick_axis_calibrated_map
// Maps a 10-bit stick sample onto a calibrated 0..254 axis value with end
// margins, a centre dead band and saturation.
// ----------------------------------------------------------------------------
module joystick_axis_calibrated_map
  import jacm_pkg::*;
#(
  parameter int unsigned INDEX_SPAN = INDEX_SPAN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  jacm_sample_if.sink   sample_i,
  jacm_result_if.source result_o,
  jacm_cfg_if.sink      cfg_i
);

  localparam int unsigned IDX_W    = $clog2(INDEX_SPAN);
  localparam int unsigned DIV_BASE = 3;
  localparam int unsigned NSTG     = NUM_W + 4;
  localparam int unsigned LAST     = NSTG - 1;

  typedef struct packed {
    logic neg;
    logic den_zero;
    logic upper;
    ovr_e ovr;
    logic clamped;
  } side_t;

  // Calibration registers
  logic [SAMPLE_W-1:0] axis_min_q, axis_mid_q, axis_max_q;
  logic [MARGIN_W-1:0] early_stop_q, dead_band_q;
  logic                invert_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_min_q   <= AXIS_MIN_RST;
      axis_mid_q   <= AXIS_MID_RST;
      axis_max_q   <= AXIS_MAX_RST;
      early_stop_q <= EARLY_STOP_RST;
      dead_band_q  <= DEAD_BAND_RST;
      invert_q     <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_AXIS_MIN:    axis_min_q   <= cfg_i.data;
        CFG_AXIS_MID:    axis_mid_q   <= cfg_i.data;
        CFG_AXIS_MAX:    axis_max_q   <= cfg_i.data;
        CFG_EARLY_STOP:  early_stop_q <= cfg_i.data[MARGIN_W-1:0];
        CFG_DEAD_BAND:   dead_band_q  <= cfg_i.data[MARGIN_W-1:0];
        CFG_INVERT_AXIS: invert_q     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance
  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] valid_in;

  always_comb begin
    en[LAST] = !valid_q[LAST] || result_o.ready;
    for (int k = int'(LAST) - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign valid_in       = {valid_q[NSTG-2:0], sample_i.valid};
  assign sample_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= (en & valid_in) | (~en & valid_q);
    end
  end

  // Stage A: invert, offset, halve, clamp
  logic signed [CAL_W-1:0] a_half;
  logic [SAMPLE_W-1:0]     a_sample;
  logic [IDX_W-1:0]        a_idx_d, a_idx_q;
  logic                    a_clamp_d, a_clamp_q;

  always_comb begin
    a_sample  = invert_q ? SAMPLE_MAX - sample_i.raw_sample : sample_i.raw_sample;
    a_half    = half_diff(a_sample, axis_min_q);
    a_idx_d   = a_half[IDX_W-1:0];
    a_clamp_d = 1'b0;
    if (a_half[CAL_W-1]) begin
      a_idx_d   = '0;
      a_clamp_d = 1'b1;
    end else if (a_half > $signed(CAL_W'(INDEX_SPAN - 1))) begin
      a_idx_d   = IDX_W'(INDEX_SPAN - 1);
      a_clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_idx_q   <= a_idx_d;
      a_clamp_q <= a_clamp_d;
    end
  end

  // Stage B: pick the half, its map operands and any forced value
  logic signed [CAL_W-1:0] b_idx, b_cm, b_cx, b_es, b_db, b_lo_den, b_hi_lo;
  logic signed [CAL_W-1:0] b_x_d, b_x_q, b_den_d, b_den_q;
  logic                    b_upper_d, b_upper_q, b_clamp_q;
  ovr_e                    b_ovr_d, b_ovr_q;

  always_comb begin
    b_idx    = $signed(CAL_W'(a_idx_q));
    b_cm     = half_diff(axis_mid_q, axis_min_q);
    b_cx     = half_diff(axis_max_q, axis_min_q);
    b_es     = $signed(CAL_W'(early_stop_q));
    b_db     = $signed(CAL_W'(dead_band_q));
    b_lo_den = b_cm - b_db;
    b_hi_lo  = b_cm + b_db;
    if (b_idx < b_cm) begin
      b_upper_d = 1'b0;
      b_x_d     = b_idx;
      b_den_d   = b_lo_den;
      b_ovr_d   = (b_idx > b_es) ? OVR_NONE : OVR_ZERO;
    end else begin
      b_upper_d = 1'b1;
      b_x_d     = b_idx - b_hi_lo;
      b_den_d   = b_cx - b_hi_lo;
      b_ovr_d   = (b_idx < b_cx - b_es) ? OVR_NONE : OVR_FULL;
    end
    // dead band wins over everything
    if (b_idx < b_hi_lo && b_idx > b_lo_den) begin
      b_ovr_d = OVR_CENTRE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_x_q     <= b_x_d;
      b_den_q   <= b_den_d;
      b_upper_q <= b_upper_d;
      b_ovr_q   <= b_ovr_d;
      b_clamp_q <= a_clamp_q;
    end
  end

  // Stage C: scale by the gain, split into sign and magnitudes
  logic signed [PROD_W-1:0] c_px, c_prod, c_prod_abs;
  logic signed [CAL_W-1:0]  c_den_abs;
  logic [NUM_W-1:0]         c_num_q;
  logic [DEN_W-1:0]         c_den_q;
  side_t                    c_side_d, c_side_q;

  always_comb begin
    c_px       = {{(PROD_W-CAL_W){b_x_q[CAL_W-1]}}, b_x_q};
    c_prod     = (c_px <<< GAIN_SHIFT) - c_px;
    c_prod_abs = c_prod[PROD_W-1] ? -c_prod : c_prod;
    c_den_abs  = b_den_q[CAL_W-1] ? -b_den_q : b_den_q;
    c_side_d.neg      = c_prod[PROD_W-1] ^ b_den_q[CAL_W-1];
    c_side_d.den_zero = (b_den_q == '0);
    c_side_d.upper    = b_upper_q;
    c_side_d.ovr      = b_ovr_q;
    c_side_d.clamped  = b_clamp_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_num_q  <= c_prod_abs[NUM_W-1:0];
      c_den_q  <= c_den_abs[DEN_W-1:0];
      c_side_q <= c_side_d;
    end
  end

  // Restoring divider: one quotient bit per stage, quotient shifts into the
  // dividend register as the dividend shifts out
  logic [NUM_W-1:0] div_nq_q   [NUM_W];
  logic [DEN_W-1:0] div_rem_q  [NUM_W];
  logic [DEN_W-1:0] div_den_q  [NUM_W];
  side_t            div_side_q [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in, den_in;
    side_t            side_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign nq_in   = c_num_q;
      assign rem_in  = '0;
      assign den_in  = c_den_q;
      assign side_in = c_side_q;
    end else begin : g_next
      assign nq_in   = div_nq_q[j-1];
      assign rem_in  = div_rem_q[j-1];
      assign den_in  = div_den_q[j-1];
      assign side_in = div_side_q[j-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en[DIV_BASE+j]) begin
        div_nq_q[j]   <= {nq_in[NUM_W-2:0], ge};
        div_rem_q[j]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        div_den_q[j]  <= den_in;
        div_side_q[j] <= side_in;
      end
    end
  end

  // Final stage: sign, offset, saturate, apply forced values
  side_t                    f_side;
  logic signed [PROD_W-1:0] f_q, f_base, f_v;
  logic [VALUE_W-1:0]       f_value_d, f_value_q;
  logic                     f_clamp_q;

  always_comb begin
    f_side = div_side_q[NUM_W-1];
    f_q    = $signed({{(PROD_W-NUM_W){1'b0}}, div_nq_q[NUM_W-1]});
    f_base = f_side.upper ? $signed({{(PROD_W-VALUE_W){1'b0}}, VALUE_CENTRE}) : '0;
    if (f_side.neg) begin
      f_q = -f_q;
    end
    f_v = f_side.den_zero ? f_base : f_q + f_base;
    priority if (f_v < 0) begin
      f_value_d = VALUE_LOW;
    end else if (f_v > $signed({{(PROD_W-VALUE_W){1'b0}}, VALUE_FULL})) begin
      f_value_d = VALUE_FULL;
    end else begin
      f_value_d = f_v[VALUE_W-1:0];
    end
    unique case (f_side.ovr)
      OVR_ZERO:   f_value_d = VALUE_LOW;
      OVR_CENTRE: f_value_d = VALUE_CENTRE;
      OVR_FULL:   f_value_d = VALUE_FULL;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      f_value_q <= f_value_d;
      f_clamp_q <= f_side.clamped;
    end
  end

  assign result_o.valid         = valid_q[LAST];
  assign result_o.axis_value    = f_value_q;
  assign result_o.index_clamped = f_clamp_q;

endmodule
